>>> hdl/pdlc_pkg.sv
package pdlc_pkg;

  localparam int CODE_LEN = 5;
  localparam int IDX_W    = $clog2(CODE_LEN + 1);
  localparam int ADDR_W   = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;

  localparam logic [7:0] START_BYTE  = 8'h15;
  localparam logic [7:0] OPEN_CMD    = 8'h2B;
  localparam logic [7:0] CHANGE_CMD  = 8'h2D;
  localparam logic [7:0] RESETUP_CMD = 8'h11;
  localparam logic [7:0] WAIT_BYTE   = 8'h20;
  localparam logic [7:0] REPLY_OK    = 8'h01;
  localparam logic [7:0] REPLY_FAIL  = 8'h00;

  localparam logic [7:0] MOTOR_SECONDS_RST   = 8'd15;
  localparam logic [7:0] LOCKOUT_SECONDS_RST = 8'd60;
  localparam logic [2:0] MAX_FAILURES_RST    = 3'd3;
  localparam logic [2:0] FAIL_SAT            = 3'd7;

  localparam logic [1:0] CFG_MOTOR_SECONDS   = 2'd0;
  localparam logic [1:0] CFG_LOCKOUT_SECONDS = 2'd1;
  localparam logic [1:0] CFG_MAX_FAILURES    = 2'd2;

  localparam logic [1:0] MOTOR_STOP    = 2'd0;
  localparam logic [1:0] MOTOR_FORWARD = 2'd1;
  localparam logic [1:0] MOTOR_REVERSE = 2'd2;

  typedef enum logic [3:0] {
    PH_SWAIT1  = 4'd0,
    PH_SREAD1  = 4'd1,
    PH_SWAIT2  = 4'd2,
    PH_SREAD2  = 4'd3,
    PH_IDLE    = 4'd4,
    PH_CWAIT   = 4'd5,
    PH_CREAD   = 4'd6,
    PH_OPENING = 4'd7,
    PH_HOLD    = 4'd8,
    PH_CLOSING = 4'd9,
    PH_LOCKOUT = 4'd10
  } phase_e;

endpackage

>>> hdl/password_door_lock_controller.sv
// channel  signals                                  direction
// ------   ---------------------------------------  ---------
// in       in_valid_i/in_ready_o, op/rx_byte/motion  input
// out      out_valid_o/out_ready_i, tx/motor/alarm   output
// cfg      cfg_we_i, cfg_index_i, cfg_wdata_i        input
//
// one item per cycle while the result register can take it: the step is computed
// from the state registers and the input ports and lands in the result register on
// the transfer edge; result valid is registered and set on that same edge
// input is taken whenever the result register is empty or being drained
// reset puts the controller in setup (wait for first frame), defaults in
// the settings registers; the saved code bank holds no value until a setup passes
module password_door_lock_controller (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       op_i,
  input  logic [7:0] rx_byte_i,
  input  logic       motion_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       tx_valid_o,
  output logic [7:0] tx_byte_o,
  output logic [1:0] motor_drive_o,
  output logic       alarm_on_o,
  output logic [3:0] phase_now_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_wdata_i
);

  localparam logic [pdlc_pkg::IDX_W-1:0] LAST_IDX = pdlc_pkg::IDX_W'(pdlc_pkg::CODE_LEN);

  logic [7:0] motor_sec_q, lockout_sec_q;
  logic [2:0] max_fail_q;

  pdlc_pkg::phase_e phase_q, phase_d;
  logic [pdlc_pkg::IDX_W-1:0] idx_q, idx_d, idx_inc;
  logic       mismatch_q, mismatch_d;
  logic       pend_open_q, pend_open_d;
  logic [2:0] fail_cnt_q, fail_cnt_d, fail_inc;
  logic [7:0] tick_q, tick_d, tick_inc;
  logic       bank_q, bank_d;

  // two code banks: saved code lives in bank_q, a new first entry in the other
  logic [7:0] code_q [2][pdlc_pkg::CODE_LEN];
  logic       code_we;
  logic       rd_bank;
  logic [pdlc_pkg::ADDR_W-1:0] addr;
  logic [7:0] rd_byte;
  logic       last, differ;

  logic       acc;
  logic       out_valid_q;
  logic       tx_valid_q, tx_valid_d;
  logic [7:0] tx_byte_q, tx_byte_d;
  logic [1:0] motor_q, motor_d;
  logic       buzzer_q, buzzer_d;
  logic [3:0] phase_out_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign acc        = in_valid_i && in_ready_o;

  assign addr     = idx_q[pdlc_pkg::ADDR_W-1:0];
  assign rd_bank  = (phase_q == pdlc_pkg::PH_SREAD2) ? !bank_q : bank_q;
  assign rd_byte  = code_q[rd_bank][addr];
  assign idx_inc  = idx_q + 1'b1;
  assign last     = (idx_inc == LAST_IDX);
  assign differ   = (rd_byte != rx_byte_i);
  assign tick_inc = (tick_q == 8'hFF) ? tick_q : tick_q + 8'd1;
  assign fail_inc = (fail_cnt_q == pdlc_pkg::FAIL_SAT) ? fail_cnt_q : fail_cnt_q + 3'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_sec_q   <= pdlc_pkg::MOTOR_SECONDS_RST;
      lockout_sec_q <= pdlc_pkg::LOCKOUT_SECONDS_RST;
      max_fail_q    <= pdlc_pkg::MAX_FAILURES_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        pdlc_pkg::CFG_MOTOR_SECONDS:   motor_sec_q   <= cfg_wdata_i;
        pdlc_pkg::CFG_LOCKOUT_SECONDS: lockout_sec_q <= cfg_wdata_i;
        pdlc_pkg::CFG_MAX_FAILURES:    max_fail_q    <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d     = phase_q;
    idx_d       = idx_q;
    mismatch_d  = mismatch_q;
    pend_open_d = pend_open_q;
    fail_cnt_d  = fail_cnt_q;
    tick_d      = tick_q;
    bank_d      = bank_q;
    code_we     = 1'b0;
    tx_valid_d  = 1'b0;
    tx_byte_d   = 8'h00;
    if (!op_i) begin
      case (phase_q)
        pdlc_pkg::PH_SWAIT1, pdlc_pkg::PH_SWAIT2, pdlc_pkg::PH_CWAIT: begin
          if (rx_byte_i == pdlc_pkg::START_BYTE) begin
            phase_d    = pdlc_pkg::phase_e'(phase_q + 4'd1);
            idx_d      = '0;
            mismatch_d = 1'b0;
          end
        end
        pdlc_pkg::PH_SREAD1: begin
          code_we = 1'b1;
          idx_d   = idx_inc;
          if (last) phase_d = pdlc_pkg::PH_SWAIT2;
        end
        pdlc_pkg::PH_SREAD2, pdlc_pkg::PH_CREAD: begin
          mismatch_d = mismatch_q || differ;
          idx_d      = idx_inc;
          if (last) begin
            tx_valid_d = 1'b1;
            if (!mismatch_d) begin
              tx_byte_d = pdlc_pkg::REPLY_OK;
              if (phase_q == pdlc_pkg::PH_SREAD2) begin
                // new code becomes the saved one
                bank_d  = !bank_q;
                phase_d = pdlc_pkg::PH_IDLE;
              end else begin
                fail_cnt_d = '0;
                tick_d     = '0;
                phase_d    = pend_open_q ? pdlc_pkg::PH_OPENING : pdlc_pkg::PH_SWAIT1;
              end
            end else begin
              tx_byte_d = pdlc_pkg::REPLY_FAIL;
              if (phase_q == pdlc_pkg::PH_SREAD2) begin
                phase_d = pdlc_pkg::PH_IDLE;
              end else begin
                fail_cnt_d = fail_inc;
                if (fail_inc >= max_fail_q) begin
                  tick_d  = '0;
                  phase_d = pdlc_pkg::PH_LOCKOUT;
                end else begin
                  phase_d = pdlc_pkg::PH_IDLE;
                end
              end
            end
          end
        end
        pdlc_pkg::PH_IDLE: begin
          if (rx_byte_i == pdlc_pkg::OPEN_CMD || rx_byte_i == pdlc_pkg::CHANGE_CMD) begin
            pend_open_d = (rx_byte_i == pdlc_pkg::OPEN_CMD);
            phase_d     = pdlc_pkg::PH_CWAIT;
          end else if (rx_byte_i == pdlc_pkg::RESETUP_CMD) begin
            phase_d = pdlc_pkg::PH_SWAIT1;
          end
        end
        default: ;
      endcase
    end else begin
      case (phase_q)
        pdlc_pkg::PH_OPENING: begin
          tick_d = tick_inc;
          if (tick_inc >= motor_sec_q) phase_d = pdlc_pkg::PH_HOLD;
        end
        pdlc_pkg::PH_HOLD: begin
          tx_valid_d = 1'b1;
          if (motion_i) begin
            tx_byte_d = pdlc_pkg::WAIT_BYTE;
          end else begin
            tx_byte_d = pdlc_pkg::REPLY_FAIL;
            tick_d    = '0;
            phase_d   = pdlc_pkg::PH_CLOSING;
          end
        end
        pdlc_pkg::PH_CLOSING: begin
          tick_d = tick_inc;
          if (tick_inc >= motor_sec_q) phase_d = pdlc_pkg::PH_IDLE;
        end
        pdlc_pkg::PH_LOCKOUT: begin
          tick_d = tick_inc;
          if (tick_inc >= lockout_sec_q) begin
            fail_cnt_d = '0;
            phase_d    = pdlc_pkg::PH_IDLE;
          end
        end
        default: ;
      endcase
    end
    case (phase_d)
      pdlc_pkg::PH_OPENING: motor_d = pdlc_pkg::MOTOR_FORWARD;
      pdlc_pkg::PH_CLOSING: motor_d = pdlc_pkg::MOTOR_REVERSE;
      default:              motor_d = pdlc_pkg::MOTOR_STOP;
    endcase
    buzzer_d = (phase_d == pdlc_pkg::PH_LOCKOUT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= pdlc_pkg::PH_SWAIT1;
      idx_q       <= '0;
      mismatch_q  <= 1'b0;
      pend_open_q <= 1'b0;
      fail_cnt_q  <= '0;
      tick_q      <= '0;
      bank_q      <= 1'b0;
    end else if (acc) begin
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      mismatch_q  <= mismatch_d;
      pend_open_q <= pend_open_d;
      fail_cnt_q  <= fail_cnt_d;
      tick_q      <= tick_d;
      bank_q      <= bank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && code_we) begin
      code_q[!bank_q][addr] <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      tx_valid_q  <= tx_valid_d;
      tx_byte_q   <= tx_byte_d;
      motor_q     <= motor_d;
      buzzer_q    <= buzzer_d;
      phase_out_q <= phase_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign tx_valid_o    = tx_valid_q;
  assign tx_byte_o     = tx_byte_q;
  assign motor_drive_o = motor_q;
  assign alarm_on_o    = buzzer_q;
  assign phase_now_o   = phase_out_q;

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= LAST_IDX)
    else $error("byte index beyond code length");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> out_valid_o)
    else $error("accepted item gave no result");

  a_quiet_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !tx_valid_o) |-> (tx_byte_o == 8'h00))
    else $error("reply byte set without reply");

  a_buzzer_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (alarm_on_o == (phase_now_o == pdlc_pkg::PH_LOCKOUT)))
    else $error("buzzer and phase disagree");

  a_motor_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && motor_drive_o != pdlc_pkg::MOTOR_STOP) |->
      (phase_now_o == pdlc_pkg::PH_OPENING || phase_now_o == pdlc_pkg::PH_CLOSING))
    else $error("motor runs outside opening or closing");
`endif

endmodule

>>> verif/password_door_lock_controller_tb.sv
`timescale 1ns / 100ps

module password_door_lock_controller_tb;
  import pdlc_pkg::*;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [1:0] motor;
    logic       buzzer;
    phase_e     phase;
  } lock_outcome_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       op;
  logic [7:0] rx_byte;
  logic       motion;
  logic       out_valid;
  logic       out_ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic [1:0] motor_drive;
  logic       alarm_on;
  logic [3:0] phase_now;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;

  // predicted lock state
  phase_e     lk_phase;
  logic [7:0] stored_pin [CODE_LEN];
  logic [7:0] setup_pin [CODE_LEN];
  logic [2:0] pin_pos;
  bit         pin_bad;
  bit         open_requested;
  logic [2:0] fail_tally;
  logic [7:0] sec_count;
  bit         pin_known;
  logic [7:0] run_secs;
  logic [7:0] alarm_secs;
  logic [2:0] fail_limit;

  lock_outcome_t pending_outcomes [$];
  lock_outcome_t want;
  int            fail_count;

  // sender pacing
  int unsigned burst_left;
  int unsigned gap_left;
  bit          offering;

  password_door_lock_controller dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .op_i         (op),
    .rx_byte_i    (rx_byte),
    .motion_i     (motion),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .tx_valid_o   (tx_valid),
    .tx_byte_o    (tx_byte),
    .motor_drive_o(motor_drive),
    .alarm_on_o   (alarm_on),
    .phase_now_o  (phase_now),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit count_tick(input logic [7:0] limit);
    if (sec_count != 8'hFF) sec_count++;
    return sec_count >= limit;
  endfunction

  // advances the lock state by one transfer and queues the outcome it causes
  task automatic apply_lock_step(input logic o, input logic [7:0] b, input logic mm,
                                 output bit acted);
    lock_outcome_t r;
    r = '0;
    acted = 1'b1;
    if (!o) begin
      case (lk_phase)
        PH_SWAIT1, PH_SWAIT2, PH_CWAIT: begin
          if (b == START_BYTE) begin
            lk_phase = phase_e'(lk_phase + 4'd1);
            pin_pos = '0;
            pin_bad = 1'b0;
          end else begin
            acted = 1'b0;
          end
        end
        PH_SREAD1: begin
          setup_pin[pin_pos] = b;
          pin_pos++;
          if (pin_pos == CODE_LEN) lk_phase = PH_SWAIT2;
        end
        PH_SREAD2: begin
          if (setup_pin[pin_pos] != b) pin_bad = 1'b1;
          pin_pos++;
          if (pin_pos == CODE_LEN) begin
            r.tx_valid = 1'b1;
            if (!pin_bad) begin
              stored_pin = setup_pin;
              pin_known = 1'b1;
              r.tx_byte = REPLY_OK;
            end else begin
              r.tx_byte = REPLY_FAIL;
            end
            lk_phase = PH_IDLE;
          end
        end
        PH_IDLE: begin
          if (b == OPEN_CMD || b == CHANGE_CMD) begin
            open_requested = (b == OPEN_CMD);
            lk_phase = PH_CWAIT;
          end else if (b == RESETUP_CMD) begin
            lk_phase = PH_SWAIT1;
          end else begin
            acted = 1'b0;
          end
        end
        PH_CREAD: begin
          if (stored_pin[pin_pos] != b) pin_bad = 1'b1;
          pin_pos++;
          if (pin_pos == CODE_LEN) begin
            r.tx_valid = 1'b1;
            if (!pin_bad) begin
              r.tx_byte = REPLY_OK;
              fail_tally = '0;
              sec_count = '0;
              lk_phase = open_requested ? PH_OPENING : PH_SWAIT1;
            end else begin
              r.tx_byte = REPLY_FAIL;
              if (fail_tally != FAIL_SAT) fail_tally++;
              if (fail_tally >= fail_limit) begin
                sec_count = '0;
                lk_phase = PH_LOCKOUT;
              end else begin
                lk_phase = PH_IDLE;
              end
            end
          end
        end
        default: acted = 1'b0;
      endcase
    end else begin
      case (lk_phase)
        PH_OPENING: begin
          if (count_tick(run_secs)) lk_phase = PH_HOLD;
        end
        PH_HOLD: begin
          r.tx_valid = 1'b1;
          if (mm) begin
            r.tx_byte = WAIT_BYTE;
          end else begin
            r.tx_byte = REPLY_FAIL;
            sec_count = '0;
            lk_phase = PH_CLOSING;
          end
        end
        PH_CLOSING: begin
          if (count_tick(run_secs)) lk_phase = PH_IDLE;
        end
        PH_LOCKOUT: begin
          if (count_tick(alarm_secs)) begin
            fail_tally = '0;
            lk_phase = PH_IDLE;
          end
        end
        default: acted = 1'b0;
      endcase
    end
    r.motor = (lk_phase == PH_OPENING) ? MOTOR_FORWARD :
              (lk_phase == PH_CLOSING) ? MOTOR_REVERSE : MOTOR_STOP;
    r.buzzer = (lk_phase == PH_LOCKOUT);
    r.phase = lk_phase;
    pending_outcomes.push_back(r);
  endtask

  task automatic send_item(input logic o, input logic [7:0] b, input logic mm,
                           output bit counted);
    if (gap_left != 0) begin
      repeat (gap_left) @(negedge clk);
      gap_left = 0;
    end
    if (burst_left == 0) begin
      // now and then a long burst with no idle cycles at all
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    op       <= o;
    rx_byte  <= b;
    motion   <= mm;
    do @(posedge clk); while (!in_ready);
    apply_lock_step(o, b, mm, counted);
    @(negedge clk);
    burst_left--;
    offering = 1'b1;
    if (burst_left == 0) begin
      gap_left = $urandom_range(0, 4);
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        offering = 1'b0;
      end
    end
  endtask

  task automatic wait_for_results();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    while (pending_outcomes.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] motor_s, input logic [7:0] alarm_s,
                                input logic [2:0] fails);
    wait_for_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MOTOR_SECONDS;
    cfg_wdata <= motor_s;
    @(negedge clk);
    cfg_index <= CFG_LOCKOUT_SECONDS;
    cfg_wdata <= alarm_s;
    @(negedge clk);
    cfg_index <= CFG_MAX_FAILURES;
    cfg_wdata <= {5'd0, fails};
    @(negedge clk);
    cfg_we <= 1'b0;
    run_secs   = motor_s;
    alarm_secs = alarm_s;
    fail_limit = fails;
  endtask

  function automatic logic [7:0] rand_byte();
    if ($urandom_range(0, 3) != 0) return 8'($urandom);
    case ($urandom_range(0, 5))
      0:       return START_BYTE;
      1:       return OPEN_CMD;
      2:       return CHANGE_CMD;
      3:       return RESETUP_CMD;
      4:       return WAIT_BYTE;
      default: return 8'hFF;
    endcase
  endfunction

  // mostly well-formed frames and commands for the current phase, some noise
  task automatic pick_item(output logic o, output logic [7:0] b, output logic mm);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    o  = 1'b0;
    b  = rand_byte();
    mm = ($urandom_range(0, 1) != 0);
    case (lk_phase)
      PH_SWAIT1, PH_SWAIT2, PH_CWAIT: begin
        if (roll < 75) b = START_BYTE;
        else if (roll < 85) o = 1'b1;
      end
      PH_SREAD1: begin
        if (roll < 5) o = 1'b1;
      end
      PH_SREAD2: begin
        if (roll < 92) b = setup_pin[pin_pos];
        else if (roll < 95) o = 1'b1;
      end
      PH_IDLE: begin
        if (roll < 40) b = OPEN_CMD;
        else if (roll < 60) b = CHANGE_CMD;
        else if (roll < 68) b = RESETUP_CMD;
        else if (roll < 78) o = 1'b1;
        // no command compare until a code has been stored
        if (!pin_known && (b == OPEN_CMD || b == CHANGE_CMD)) b = RESETUP_CMD;
      end
      PH_CREAD: begin
        if (roll < 92) b = stored_pin[pin_pos];
        else if (roll < 95) o = 1'b1;
      end
      PH_HOLD: begin
        if (roll < 85) begin
          o  = 1'b1;
          mm = (roll < 50);
        end
      end
      default: begin
        if (roll < 85) o = 1'b1;
      end
    endcase
  endtask

  task automatic run_random_items(input int n);
    int         done;
    bit         counted;
    logic       o;
    logic [7:0] b;
    logic       mm;
    done = 0;
    while (done < n) begin
      pick_item(o, b, mm);
      send_item(o, b, mm, counted);
      if (counted) done++;
    end
  endtask

  task automatic test_directed_open_cycle();
    logic [7:0] pin [CODE_LEN];
    bit         counted;
    pin = '{START_BYTE, 8'hFF, 8'h00, OPEN_CMD, RESETUP_CMD};
    apply_settings(8'd1, 8'd2, 3'd2);
    send_item(1'b1, 8'h00, 1'b1, counted);
    send_item(1'b0, 8'hAA, 1'b0, counted);
    send_item(1'b0, START_BYTE, 1'b0, counted);
    // start byte inside a frame is code data
    for (int i = 0; i < CODE_LEN; i++) send_item(1'b0, pin[i], 1'b0, counted);
    send_item(1'b0, START_BYTE, 1'b1, counted);
    for (int i = 0; i < CODE_LEN; i++) send_item(1'b0, pin[i], 1'b1, counted);
    send_item(1'b0, 8'h55, 1'b0, counted);
    send_item(1'b0, OPEN_CMD, 1'b0, counted);
    send_item(1'b0, START_BYTE, 1'b0, counted);
    for (int i = 0; i < CODE_LEN; i++) send_item(1'b0, pin[i], 1'b0, counted);
    send_item(1'b0, CHANGE_CMD, 1'b1, counted);
    send_item(1'b1, 8'hFF, 1'b1, counted);
    send_item(1'b1, 8'h00, 1'b1, counted);
    send_item(1'b1, 8'h00, 1'b0, counted);
    send_item(1'b1, 8'hFF, 1'b0, counted);
  endtask

  task automatic test_short_timing();
    apply_settings(8'd3, 8'd4, 3'd3);
    run_random_items(50);
  endtask

  task automatic test_lowest_settings();
    apply_settings(8'd1, 8'd1, 3'd1);
    run_random_items(40);
  endtask

  // zero limits end a timed phase on its first tick, zero failures lock out at once
  task automatic test_zero_settings();
    apply_settings(8'd0, 8'd0, 3'd0);
    run_random_items(35);
  endtask

  task automatic test_highest_settings();
    apply_settings(8'd255, 8'd255, 3'd7);
    run_random_items(130);
  endtask

  task automatic test_random_settings();
    for (int k = 0; k < 3; k++) begin
      apply_settings(8'($urandom_range(1, 6)), 8'($urandom_range(1, 8)),
                     3'($urandom_range(1, 7)));
      run_random_items(20);
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    op        = 1'b0;
    rx_byte   = '0;
    motion    = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_MOTOR_SECONDS;
    cfg_wdata = '0;
    fail_count = 0;
    burst_left = 0;
    gap_left   = 0;
    offering   = 1'b0;
    lk_phase       = PH_SWAIT1;
    pin_pos        = '0;
    pin_bad        = 1'b0;
    open_requested = 1'b0;
    fail_tally     = '0;
    sec_count      = '0;
    pin_known      = 1'b0;
    run_secs       = MOTOR_SECONDS_RST;
    alarm_secs     = LOCKOUT_SECONDS_RST;
    fail_limit     = MAX_FAILURES_RST;
    for (int i = 0; i < CODE_LEN; i++) begin
      stored_pin[i] = '0;
      setup_pin[i]  = '0;
    end
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_open_cycle();
    test_short_timing();
    test_lowest_settings();
    test_zero_settings();
    test_highest_settings();
    test_random_settings();
    wait_for_results();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // result side stalls in stretches: always ready, random, one in four, mostly ready
  initial begin : result_stall
    int unsigned mode;
    int unsigned left;
    out_ready = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(10, 80);
      end
      left--;
      case (mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 1) != 0);
        2:       out_ready <= (left[1:0] == 2'b00);
        default: out_ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  task automatic check_field(input string name, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t ns: result transfer with none expected, actual tx %0h/0x%0h phase %0d",
                 $time, tx_valid, tx_byte, phase_now);
        fail_count++;
      end else begin
        want = pending_outcomes.pop_front();
        check_field("tx_valid", 8'(want.tx_valid), 8'(tx_valid));
        check_field("tx_byte", want.tx_byte, tx_byte);
        check_field("motor_drive", 8'(want.motor), 8'(motor_drive));
        check_field("alarm_on", 8'(want.buzzer), 8'(alarm_on));
        check_field("phase_now", 8'(want.phase), 8'(phase_now));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> filelist.f
hdl/pdlc_pkg.sv
hdl/password_door_lock_controller.sv
verif/password_door_lock_controller_tb.sv
